FILE: design/acn_pkg.sv
// Shared codes and controller/datapath command and status types.
package acn_pkg;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;

    // quotient bits the serial divider produces below its overflow limit
    localparam int QUO_BITS = 17;

    typedef struct packed {
        logic capture;    // take the input transfer, read the table at its axis
        logic wr_item;    // write back the sampled axis
        logic cal;        // calibration open
        logic cal_open;   // clear touched bits, zero the centres
        logic cal_close;  // centres are valid again
        logic walk_clr;
        logic walk_rd;
        logic walk_wr;
        logic walk_inc;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       in_range;
        logic       walk_last;
        logic       div_done;
        logic       out_full;
    } t_sts;

endpackage

FILE: design/acn_if.sv
// Valid/ready stream interfaces for axis samples and normalized results.
interface acn_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [3:0]         axis_index;
    logic signed [15:0] sample;

    modport source (output valid, kind, axis_index, sample, input ready);
    modport sink   (input valid, kind, axis_index, sample, output ready);
endinterface

interface acn_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_axis;
    logic signed [15:0] normalized;
    logic               saturated;

    modport source (output valid, out_axis, normalized, saturated, input ready);
    modport sink   (input valid, out_axis, normalized, saturated, output ready);
endinterface

FILE: design/acn_div.sv
// Restoring divider, one quotient bit per cycle, of (mag << 15) by den.
module acn_div import acn_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [15:0]         i_mag,
    input  logic [16:0]         i_den,
    output logic                o_done,
    output logic                o_ovf,
    output logic [QUO_BITS-1:0] o_quo
);

    logic                r_busy;
    logic                r_done;
    logic [4:0]          r_cnt;
    logic                r_ovf;
    logic [16:0]         r_den;
    logic [16:0]         r_rem;
    logic [16:0]         r_sh;
    logic [QUO_BITS-1:0] r_quo;

    logic [17:0] w_try;
    logic [17:0] w_diff;
    logic        w_ge;
    logic        w_ovf;

    assign w_try  = {r_rem, r_sh[16]};
    assign w_diff = w_try - {1'b0, r_den};
    assign w_ge   = (w_try >= {1'b0, r_den});
    // quotient reaches 2^17 exactly when mag >= 4*den
    assign w_ovf  = ({3'b000, i_mag[15:2]} >= i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (w_ovf) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(QUO_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= w_ovf;
            r_den <= i_den;
            r_rem <= {3'b000, i_mag[15:2]};
            r_sh  <= {i_mag[1:0], 15'd0};
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[16:0] : w_try[16:0];
            r_sh  <= {r_sh[15:0], 1'b0};
            r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quo  = r_quo;

endmodule

FILE: design/acn_dp.sv
// Datapath: axis table, calibration update, division setup and result register.
module acn_dp import acn_pkg::*; #(
    parameter int AXIS_COUNT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [1:0]         i_kind,
    input  logic [3:0]         i_axis,
    input  logic signed [15:0] i_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_axis,
    output logic signed [15:0] o_norm,
    output logic               o_sat
);

    localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int XW = (AW > 4) ? AW : 4;

    localparam logic signed [16:0] MIN_RST  = 17'h18000;  // -32768
    localparam logic signed [16:0] MAX_RST  = 17'h08000;  // 32768
    localparam logic signed [16:0] MAX_OPEN = 17'h07FFF;  // 32767

    typedef struct packed {
        logic signed [16:0] mn;
        logic signed [16:0] mx;
        logic signed [15:0] cen;
        logic signed [15:0] last;
    } t_rec;

    t_rec r_mem [AXIS_COUNT];

    logic [AXIS_COUNT-1:0] r_vld;
    logic [AXIS_COUNT-1:0] r_tch;
    logic                  r_cen_zero;
    logic [AW-1:0]         r_walk;
    logic                  r_out_vld;

    t_rec               r_rd;
    logic               r_rd_vld;
    logic               r_rd_tch;
    logic [1:0]         r_kind;
    logic [3:0]         r_axis;
    logic [AW-1:0]      r_addr;
    logic signed [15:0] r_sample;
    logic               r_inrng;
    logic               r_pos;
    logic               r_neg;
    logic               r_bad;
    logic [3:0]         r_out_axis;
    logic signed [15:0] r_out_norm;
    logic               r_out_sat;

    logic [XW-1:0]      w_axis_x;
    logic [AW-1:0]      w_in_addr;
    logic               w_in_rng;
    logic               w_rd_en;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    t_rec               w_wdata;
    t_rec               w_eff;
    t_rec               w_item;
    t_rec               w_walk;
    logic signed [16:0] w_s17;
    logic signed [16:0] w_d;
    logic               w_dpos;
    logic               w_dneg;
    logic [17:0]        w_dv;
    logic               w_bad;
    logic [16:0]        w_mag;
    logic               w_div_done;
    logic               w_ovf;
    logic [QUO_BITS-1:0] w_quo;
    logic [QUO_BITS-1:0] w_quo_neg;
    logic signed [15:0] w_norm;
    logic               w_sat;

    assign w_axis_x  = XW'(i_axis);
    assign w_in_addr = w_axis_x[AW-1:0];
    assign w_in_rng  = (32'(i_axis) < AXIS_COUNT);

    assign w_rd_en = i_cmd.capture | i_cmd.walk_rd;
    assign w_raddr = i_cmd.walk_rd ? r_walk : w_in_addr;

    // table read, one port, registered
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd     <= r_mem[w_raddr];
            r_rd_vld <= r_vld[w_raddr];
            r_rd_tch <= r_tch[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_axis   <= i_axis;
            r_addr   <= w_in_addr;
            r_sample <= i_sample;
            r_inrng  <= w_in_rng;
        end
    end

    // entries never written read as their reset values; centres read zero
    // from calibration start until the stop walk rewrites them
    always_comb begin
        w_eff.mn   = r_rd_vld ? r_rd.mn : MIN_RST;
        w_eff.mx   = r_rd_vld ? r_rd.mx : MAX_RST;
        w_eff.cen  = (r_rd_vld && !r_cen_zero) ? r_rd.cen : 16'sd0;
        w_eff.last = r_rd_vld ? r_rd.last : 16'sd0;
    end

    assign w_s17 = {r_sample[15], r_sample};

    always_comb begin
        w_item      = w_eff;
        w_item.last = r_sample;
        if (i_cmd.cal) begin
            if (!r_rd_tch) begin
                w_item.mn = w_s17;
                w_item.mx = w_s17;
            end else begin
                if (w_s17 < w_eff.mn) w_item.mn = w_s17;
                if (w_s17 > w_eff.mx) w_item.mx = w_s17;
            end
        end
    end

    always_comb begin
        w_walk     = w_eff;
        w_walk.cen = w_eff.last;
        if (!r_rd_tch) begin
            w_walk.mn = MIN_RST;
            w_walk.mx = MAX_OPEN;
        end
    end

    assign w_we    = i_cmd.wr_item | i_cmd.walk_wr;
    assign w_waddr = i_cmd.walk_wr ? r_walk : r_addr;
    assign w_wdata = i_cmd.walk_wr ? w_walk : w_item;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_tch      <= '0;
            r_cen_zero <= 1'b1;
            r_walk     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_we) r_vld[w_waddr] <= 1'b1;
            if (i_cmd.cal_open) begin
                r_tch      <= '0;
                r_cen_zero <= 1'b1;
            end else if (i_cmd.wr_item && i_cmd.cal) begin
                r_tch[r_addr] <= 1'b1;
            end
            if (i_cmd.cal_close) r_cen_zero <= 1'b0;
            if (i_cmd.walk_clr) begin
                r_walk <= '0;
            end else if (i_cmd.walk_inc) begin
                r_walk <= r_walk + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // division setup
    assign w_d    = w_s17 - {w_eff.cen[15], w_eff.cen};
    assign w_dneg = w_d[16];
    assign w_dpos = !w_d[16] && (w_d != 17'sd0);
    assign w_dv   = w_dpos ? ({w_eff.mx[16], w_eff.mx} - {{2{w_eff.cen[15]}}, w_eff.cen})
                           : ({{2{w_eff.cen[15]}}, w_eff.cen} - {w_eff.mn[16], w_eff.mn});
    assign w_bad  = w_dv[17] || (w_dv == 18'd0);
    assign w_mag  = w_dneg ? (~w_d + 17'd1) : w_d;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_pos <= w_dpos;
            r_neg <= w_dneg;
            r_bad <= w_bad;
        end
    end

    acn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (w_mag[15:0]),
        .i_den   (w_dv[16:0]),
        .o_done  (w_div_done),
        .o_ovf   (w_ovf),
        .o_quo   (w_quo)
    );

    assign w_quo_neg = ~w_quo + 17'd1;

    // clamp to Q1.15
    always_comb begin
        w_norm = 16'sd0;
        w_sat  = 1'b0;
        if (r_pos) begin
            if (r_bad || w_ovf || (w_quo > 17'd32767)) begin
                w_norm = 16'sh7FFF;
                w_sat  = 1'b1;
            end else begin
                w_norm = w_quo[15:0];
            end
        end else if (r_neg) begin
            if (r_bad || w_ovf || (w_quo > 17'd32768)) begin
                w_norm = 16'sh8000;
                w_sat  = 1'b1;
            end else begin
                w_norm = w_quo_neg[15:0];
            end
        end else begin
            w_sat = r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_axis <= r_axis;
            r_out_norm <= w_norm;
            r_out_sat  <= w_sat;
        end
    end

    assign o_valid = r_out_vld;
    assign o_axis  = r_out_axis;
    assign o_norm  = r_out_norm;
    assign o_sat   = r_out_sat;

    assign o_sts.kind      = r_kind;
    assign o_sts.in_range  = r_inrng;
    assign o_sts.walk_last = (r_walk == AW'(AXIS_COUNT - 1));
    assign o_sts.div_done  = w_div_done;
    assign o_sts.out_full  = r_out_vld;

    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_rd_en))
        else $error("table read and write in the same cycle");

    a_div_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> (r_inrng && (r_kind == KIND_SAMPLE) && !i_cmd.cal))
        else $error("division started for an item that yields no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_vld)
        else $error("result register loaded while a result is pending");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_sat) |->
            ((r_out_norm == 16'sh7FFF) || (r_out_norm == 16'sh8000) ||
             (r_out_norm == 16'sd0)))
        else $error("saturated result not at full scale or zero");

endmodule

FILE: design/acn_ctrl.sv
// Controller: sequences lookup, update, division, result load and the stop walk.
module acn_ctrl import acn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_OUT,
        S_WALK_RD,
        S_WALK_WR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_cal;
    logic   n_cal;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cal   = r_cal;
        o_cmd   = '0;
        o_cmd.cal = r_cal;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_sts.kind)
                    KIND_START: begin
                        o_cmd.cal_open = 1'b1;
                        n_cal = 1'b1;
                    end
                    KIND_STOP: begin
                        if (r_cal) begin
                            o_cmd.walk_clr = 1'b1;
                            n_state = S_WALK_RD;
                        end
                    end
                    KIND_SAMPLE: begin
                        if (i_sts.in_range) begin
                            o_cmd.wr_item = 1'b1;
                            if (!r_cal) begin
                                o_cmd.div_start = 1'b1;
                                n_state = S_DIV;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_WALK_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state = S_WALK_WR;
            end
            S_WALK_WR: begin
                o_cmd.walk_wr = 1'b1;
                if (i_sts.walk_last) begin
                    o_cmd.cal_close = 1'b1;
                    n_cal = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.walk_inc = 1'b1;
                    n_state = S_WALK_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cal   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cal   <= n_cal;
        end
    end

endmodule

FILE: design/axis_calibrate_normalize.sv
// Top level: per-axis min/max/centre calibration and Q1.15 normalization.
//
//  channel  dir  payload                          transfer when
//  i_in     in   kind, axis_index, sample         i_in.valid && i_in.ready
//  o_out    out  out_axis, normalized, saturated  o_out.valid && o_out.ready
//
// Sequence: a sample outside calibration raises o_out.valid after capture,
// table lookup, the 17-step serial divider, done and result load, sooner
// when the divider flags an overflowing quotient up front; the next input
// can be taken in the cycle after the result load, and none before it.
// Start items, calibrating samples and dropped items pass through capture
// and decode only. A stop item walks the single-port axis table, reading
// and then writing back each axis in turn.
// Reset clears the controller, the table valid bits and touched bits; an
// unwritten entry reads as min -32768, max 32768, centre 0, last 0.
// Stalls: the result register holds a result until taken; the next item is
// accepted meanwhile, and a second result waits in the divider, with the
// controller in S_OUT, until the register frees.
module axis_calibrate_normalize import acn_pkg::*; #(
    parameter int AXIS_COUNT = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    acn_in_if.sink    i_in,
    acn_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    // controller: mode bit and sequencing only
    acn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: table, arithmetic, divider, result register
    acn_dp #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_kind   (i_in.kind),
        .i_axis   (i_in.axis_index),
        .i_sample (i_in.sample),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_axis   (o_out.out_axis),
        .o_norm   (o_out.normalized),
        .o_sat    (o_out.saturated)
    );

endmodule

FILE: sim/axis_calibrate_normalize_tb.sv
// Self-checking testbench for the axis calibration and normalization block.
`timescale 1ns / 100ps

module axis_calibrate_normalize_tb;
    import acn_pkg::*;

    localparam int          AXES        = 16;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;  // code the block must drop
    localparam int          RANDOM_ITEMS = 1900;
    localparam int          IDLE_LIMIT  = 4000;  // cycles without any transfer
    localparam int          DRAIN_CYCLES = 60;   // divider latency plus a stop walk

    typedef struct {
        logic [3:0]         axis;
        logic signed [15:0] norm;
        logic               sat;
    } norm_result_t;

    typedef struct {
        logic [1:0]         kind;
        logic [3:0]         axis;
        logic signed [15:0] sample;
        bit                 typed;  // expected result written in the row
        logic signed [15:0] norm;
        logic               sat;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    acn_in_if  in_if ();
    acn_out_if out_if ();

    axis_calibrate_normalize #(.AXIS_COUNT(AXES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow of the calibration table
    bit                 cal_active;
    logic signed [16:0] range_lo   [AXES];
    logic signed [16:0] range_hi   [AXES];
    logic signed [15:0] centre_val [AXES];
    logic signed [15:0] last_raw   [AXES];
    bit                 seen       [AXES];

    norm_result_t expected_norm[$];
    stim_row_t    directed_rows[$];

    bit steady;  // no gaps on either side while set
    int errors;
    int items_sent;
    int results_seen;
    int sat_seen;
    int cal_passes;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, some medium, a few long ones.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic model_reset();
        cal_active = 1'b0;
        for (int i = 0; i < AXES; i++) begin
            range_lo[i]   = -17'sd32768;
            range_hi[i]   = 17'sd32768;
            centre_val[i] = '0;
            last_raw[i]   = '0;
            seen[i]       = 1'b0;
        end
    endtask

    // Updates the shadow table; returns 1 when the item yields a result.
    function automatic bit normalize_model(input logic [1:0] kind, input logic [3:0] ax,
                                           input logic signed [15:0] s,
                                           output norm_result_t res);
        longint dev;
        longint dvsr;
        longint quo;
        logic   sat;
        res.axis = ax;
        res.norm = '0;
        res.sat  = 1'b0;
        if (kind == KIND_START) begin
            // start also restarts a calibration already open
            cal_active = 1'b1;
            for (int i = 0; i < AXES; i++) begin
                seen[i]       = 1'b0;
                centre_val[i] = '0;
            end
            return 1'b0;
        end
        if (kind == KIND_STOP) begin
            if (!cal_active) return 1'b0;
            for (int i = 0; i < AXES; i++) begin
                if (!seen[i]) begin
                    range_lo[i] = -17'sd32768;
                    range_hi[i] = 17'sd32767;
                end
                centre_val[i] = last_raw[i];
            end
            cal_active = 1'b0;
            return 1'b0;
        end
        if (kind != KIND_SAMPLE) return 1'b0;

        last_raw[ax] = s;
        if (cal_active) begin
            if (!seen[ax]) begin
                range_lo[ax] = s;
                range_hi[ax] = s;
                seen[ax]     = 1'b1;
            end else begin
                if (s < range_lo[ax]) range_lo[ax] = s;
                if (s > range_hi[ax]) range_hi[ax] = s;
            end
            return 1'b0;
        end

        dev  = longint'(s) - longint'(centre_val[ax]);
        dvsr = (dev > 0) ? longint'(range_hi[ax]) - longint'(centre_val[ax])
                         : longint'(centre_val[ax]) - longint'(range_lo[ax]);
        sat  = 1'b0;
        if (dvsr <= 0) begin
            sat = 1'b1;
            quo = (dev > 0) ? 32767 : ((dev < 0) ? -32768 : 0);
        end else begin
            quo = (dev * 32768) / dvsr;
            if (quo > 32767) begin
                quo = 32767;
                sat = 1'b1;
            end else if (quo < -32768) begin
                quo = -32768;
                sat = 1'b1;
            end
        end
        res.norm = quo[15:0];
        res.sat  = sat;
        return 1'b1;
    endfunction

    // Drive one item from a falling edge and hold it until the transfer.
    task automatic send_item(input logic [1:0] kind, input logic [3:0] ax,
                             input logic signed [15:0] s, input bit typed,
                             input logic signed [15:0] norm, input logic sat);
        int           gap;
        norm_result_t res;
        norm_result_t typed_res;
        gap = pick_gap();
        @(negedge i_clk);
        repeat (gap) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.kind       <= kind;
        in_if.axis_index <= ax;
        in_if.sample     <= s;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
        if (kind == KIND_STOP && cal_active) cal_passes++;
        if (normalize_model(kind, ax, s, res)) begin
            if (typed) begin
                typed_res.axis = ax;
                typed_res.norm = norm;
                typed_res.sat  = sat;
                expected_norm.push_back(typed_res);
            end else begin
                expected_norm.push_back(res);
            end
        end
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [3:0] ax,
                           input logic signed [15:0] s, input bit typed,
                           input logic signed [15:0] norm, input logic sat);
        stim_row_t r;
        r.kind   = kind;
        r.axis   = ax;
        r.sample = s;
        r.typed  = typed;
        r.norm   = norm;
        r.sat    = sat;
        directed_rows.push_back(r);
    endtask

    // Random sample: full range, extremes, 0, -1, or a walk near centre (last value if calibrating).
    function automatic logic signed [15:0] pick_sample(input logic [3:0] ax);
        int r;
        logic signed [15:0] base;
        r = $urandom_range(0, 9);
        if (r < 4) return 16'($urandom());
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0: return -16'sd32768;
                1: return 16'sd32767;
                2: return 16'sd0;
                default: return -16'sd1;
            endcase
        end
        base = cal_active ? last_raw[ax] : centre_val[ax];
        return base + 16'($urandom_range(0, 512) - 256);
    endfunction

    // Result side: random stalls, none while steady.
    initial begin
        int n;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_if.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        norm_result_t e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (out_if.saturated) sat_seen++;
            if (expected_norm.size() == 0) begin
                $error("result with none pending: out_axis %0d normalized %0d saturated %0b",
                       out_if.out_axis, out_if.normalized, out_if.saturated);
                errors++;
            end else begin
                e = expected_norm.pop_front();
                if (out_if.out_axis !== e.axis) begin
                    $error("out_axis: expected %0d, got %0d", e.axis, out_if.out_axis);
                    errors++;
                end
                if (out_if.normalized !== e.norm) begin
                    $error("normalized: expected %0d, got %0d", e.norm, out_if.normalized);
                    errors++;
                end
                if (out_if.saturated !== e.sat) begin
                    $error("saturated: expected %0b, got %0b", e.sat, out_if.saturated);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without a transfer on either channel.
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !i_rst_n)
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: %0d cycles without a transfer", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [15:0] mask;
        logic [3:0]  ax;
        int          n;
        in_if.valid      = 1'b0;
        in_if.kind       = KIND_SAMPLE;
        in_if.axis_index = '0;
        in_if.sample     = '0;
        i_rst_n          = 1'b0;
        steady           = 1'b0;
        errors           = 0;
        items_sent       = 0;
        results_seen     = 0;
        sat_seen         = 0;
        cal_passes       = 0;
        model_reset();

        // After reset: min -32768, max 32768, centre 0.
        add_row(KIND_SAMPLE, 4'd0,  16'sd32767,  1, 16'sd32767,  1'b0);
        add_row(KIND_SAMPLE, 4'd1, -16'sd32768,  1, -16'sd32768, 1'b0);
        add_row(KIND_SAMPLE, 4'd2,  16'sd0,      1, 16'sd0,      1'b0);
        add_row(KIND_SAMPLE, 4'd15, 16'sd16384,  1, 16'sd16384,  1'b0);
        // stop outside calibration and the unused code are dropped
        add_row(KIND_STOP,   4'd7,  16'sd5,      0, '0, 1'b0);
        add_row(KIND_UNUSED, 4'd5,  16'sd1234,   0, '0, 1'b0);
        add_row(KIND_START,  4'd0,  16'sd0,      0, '0, 1'b0);
        add_row(KIND_SAMPLE, 4'd3,  16'sd100,    0, '0, 1'b0);
        add_row(KIND_SAMPLE, 4'd4, -16'sd32768,  0, '0, 1'b0);
        // restart while calibrating
        add_row(KIND_START,  4'd9, -16'sd1,      0, '0, 1'b0);
        add_row(KIND_SAMPLE, 4'd3,  16'sd100,    0, '0, 1'b0);
        add_row(KIND_SAMPLE, 4'd4, -16'sd32768,  0, '0, 1'b0);
        add_row(KIND_SAMPLE, 4'd4,  16'sd32767,  0, '0, 1'b0);
        add_row(KIND_SAMPLE, 4'd4,  16'sd0,      0, '0, 1'b0);
        add_row(KIND_SAMPLE, 4'd6, -16'sd32768,  0, '0, 1'b0);
        add_row(KIND_UNUSED, 4'd10, -16'sd1,     0, '0, 1'b0);
        add_row(KIND_STOP,   4'd0,  16'sd0,      0, '0, 1'b0);
        // axis 3 saw one value: both divisors are zero
        add_row(KIND_SAMPLE, 4'd3,  16'sd200,    1, 16'sd32767,  1'b1);
        add_row(KIND_SAMPLE, 4'd3,  16'sd100,    1, 16'sd0,      1'b1);
        add_row(KIND_SAMPLE, 4'd3,  16'sd0,      1, -16'sd32768, 1'b1);
        // axis 4 spans the full range around centre 0
        add_row(KIND_SAMPLE, 4'd4,  16'sd32767,  1, 16'sd32767,  1'b1);
        add_row(KIND_SAMPLE, 4'd4, -16'sd32768,  1, -16'sd32768, 1'b0);
        // axes 0 and 1 are untouched: centre is the last raw reading; axis 6 saw one value
        add_row(KIND_SAMPLE, 4'd0,  16'sd32767,  0, '0, 1'b0);
        add_row(KIND_SAMPLE, 4'd1, -16'sd32768,  1, 16'sd0,      1'b1);
        add_row(KIND_SAMPLE, 4'd6,  16'sd1,      0, '0, 1'b0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].axis, directed_rows[i].sample,
                      directed_rows[i].typed, directed_rows[i].norm, directed_rows[i].sat);

        // Rounds of an optional calibration session with random content, then a run of mostly samples.
        while (items_sent < RANDOM_ITEMS + directed_rows.size()) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) != 0) begin
                send_item(KIND_START, 4'($urandom()), 16'($urandom()), 0, '0, 1'b0);
                case ($urandom_range(0, 3))
                    0:       mask = 16'hffff;
                    1:       mask = 16'h1 << $urandom_range(0, 15);
                    default: mask = 16'($urandom());
                endcase
                if (mask == '0) mask = 16'h0001;
                n = $urandom_range(3, 30);
                repeat (n) begin
                    do ax = 4'($urandom()); while (!mask[ax]);
                    case ($urandom_range(0, 39))
                        0: send_item(KIND_UNUSED, ax, 16'($urandom()), 0, '0, 1'b0);
                        1: send_item(KIND_START, ax, 16'($urandom()), 0, '0, 1'b0);
                        default: send_item(KIND_SAMPLE, ax, pick_sample(ax), 0, '0, 1'b0);
                    endcase
                end
                send_item(KIND_STOP, 4'($urandom()), 16'($urandom()), 0, '0, 1'b0);
            end
            n = $urandom_range(10, 100);
            repeat (n) begin
                ax = 4'($urandom());
                case ($urandom_range(0, 49))
                    0: send_item(KIND_STOP, ax, 16'($urandom()), 0, '0, 1'b0);
                    1: send_item(KIND_UNUSED, ax, 16'($urandom()), 0, '0, 1'b0);
                    default: send_item(KIND_SAMPLE, ax, pick_sample(ax), 0, '0, 1'b0);
                endcase
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        steady = 1'b0;
        while (expected_norm.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_norm.size() != 0) begin
            $error("%0d normalized results never arrived", expected_norm.size());
            errors++;
        end

        $display("Sent %0d items over %0d calibration passes; checked %0d results (%0d saturated).",
                 items_sent, cal_passes, results_seen, sat_seen);
        $display("Mismatches: %0d", errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: axis_calibrate_normalize.f
design/acn_pkg.sv
design/acn_if.sv
design/acn_div.sv
design/acn_dp.sv
design/acn_ctrl.sv
design/axis_calibrate_normalize.sv
sim/axis_calibrate_normalize_tb.sv
